// ===== src/tga_dec_pkg.sv =====
package tga_dec_pkg;

  typedef enum logic [1:0] {
    EV_RUN    = 2'd0,
    EV_HEADER = 2'd1,
    EV_DEPTH  = 2'd2,
    EV_CLIP   = 2'd3
  } event_e;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_PLAIN  = 6'b000010,
    PH_PACKET = 6'b000100,
    PH_PIXELS = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  localparam logic [4:0] HdrImageType = 5'd2;
  localparam logic [4:0] HdrWidthLo   = 5'd12;
  localparam logic [4:0] HdrWidthHi   = 5'd13;
  localparam logic [4:0] HdrHeightLo  = 5'd14;
  localparam logic [4:0] HdrHeightHi  = 5'd15;
  localparam logic [4:0] HdrDepth     = 5'd16;
  localparam logic [4:0] HdrLast      = 5'd17;

  localparam logic [7:0] TypeTrueColor = 8'd2;
  localparam logic [7:0] TypeRle       = 8'd10;
  localparam logic [7:0] DepthBgra     = 8'd32;
  localparam logic [7:0] RepeatBias    = 8'h7f;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_word_t;

  typedef struct packed {
    event_e      kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [15:0] col_start;
    logic [15:0] row_addr;
    logic [7:0]  run_length;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        image_done;
  } result_t;

endpackage

// ===== src/tga_dec_in_reg.sv =====
module tga_dec_in_reg import tga_dec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_word_t word_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== src/tga_dec_core.sv =====
module tga_dec_core import tga_dec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t word_i,
  input  logic     step_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  logic [4:0]  hidx_q, hidx_d, hidx;
  phase_e      ph_q, ph_d, ph;
  logic [7:0]  kind_q, kind_d, kind;
  logic [15:0] wid_q, wid_d, wid;
  logic [15:0] hgt_q, hgt_d, hgt;
  logic [15:0] rows_q, rows_d, rows;
  logic [15:0] col_q, col_d, col;
  logic [7:0]  pleft_q, pleft_d, pleft;
  logic        prep_q, prep_d, prep;
  logic [1:0]  bip_q, bip_d, bip;
  logic [23:0] part_q, part_d, part;

  logic [15:0] avail;
  logic        clip;
  logic [7:0]  run_n;
  logic [16:0] col_sum;
  logic        wrap;
  logic [15:0] rows_m1;
  logic [7:0]  pleft_m1;
  logic [7:0]  data;

  assign data = word_i.data;

  // file start restarts from the reset view
  always_comb begin
    if (word_i.start) begin
      hidx  = '0;
      ph    = PH_HEADER;
      kind  = '0;
      wid   = '0;
      hgt   = '0;
      rows  = '0;
      col   = '0;
      pleft = '0;
      prep  = 1'b0;
      bip   = '0;
      part  = '0;
    end else begin
      hidx  = hidx_q;
      ph    = ph_q;
      kind  = kind_q;
      wid   = wid_q;
      hgt   = hgt_q;
      rows  = rows_q;
      col   = col_q;
      pleft = pleft_q;
      prep  = prep_q;
      bip   = bip_q;
      part  = part_q;
    end
  end

  // run length and row advance
  always_comb begin
    avail    = wid - col;
    pleft_m1 = pleft - 8'd1;
    rows_m1  = rows - 16'd1;
    if (ph == PH_PLAIN) begin
      clip  = 1'b0;
      run_n = 8'd1;
    end else if (prep) begin
      clip  = {8'b0, pleft} > avail;
      run_n = clip ? avail[7:0] : pleft;
    end else begin
      clip  = (({1'b0, col} + 17'd1) == {1'b0, wid}) && (pleft > 8'd1);
      run_n = 8'd1;
    end
    col_sum = {1'b0, col} + {9'b0, run_n};
    wrap    = col_sum >= {1'b0, wid};
  end

  always_comb begin
    hidx_d      = hidx;
    ph_d        = ph;
    kind_d      = kind;
    wid_d       = wid;
    hgt_d       = hgt;
    rows_d      = rows;
    col_d       = col;
    pleft_d     = pleft;
    prep_d      = prep;
    bip_d       = bip;
    part_d      = part;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = EV_RUN;
    case (ph)
      PH_HEADER: begin
        hidx_d = hidx + 5'd1;
        case (hidx)
          HdrImageType: kind_d = data;
          HdrWidthLo:   wid_d  = {wid[15:8], data};
          HdrWidthHi:   wid_d  = {data, wid[7:0]};
          HdrHeightLo:  hgt_d  = {hgt[15:8], data};
          HdrHeightHi:  hgt_d  = {data, hgt[7:0]};
          HdrDepth: begin
            if (data != DepthBgra) begin
              ph_d        = PH_DONE;
              res_valid_o = 1'b1;
              res_o.kind  = EV_DEPTH;
            end
          end
          HdrLast: begin
            rows_d = hgt;
            col_d  = '0;
            if (wid == '0 || hgt == '0) begin
              ph_d = PH_DONE;
            end else if (kind == TypeTrueColor) begin
              ph_d = PH_PLAIN;
            end else if (kind == TypeRle) begin
              ph_d = PH_PACKET;
            end else begin
              ph_d = PH_DONE;
            end
            res_valid_o        = 1'b1;
            res_o.kind         = EV_HEADER;
            res_o.frame_width  = wid;
            res_o.frame_height = hgt;
          end
          default: ;
        endcase
      end
      PH_PACKET: begin
        if (!data[7]) begin
          pleft_d = data + 8'd1;
          prep_d  = 1'b0;
        end else begin
          pleft_d = data - RepeatBias;
          prep_d  = 1'b1;
        end
        bip_d  = '0;
        part_d = '0;
        ph_d   = PH_PIXELS;
      end
      PH_PLAIN, PH_PIXELS: begin
        if (bip != 2'd3) begin
          part_d[{bip, 3'b000} +: 8] = part[{bip, 3'b000} +: 8] | data;
          bip_d = bip + 2'd1;
        end else begin
          bip_d            = '0;
          part_d           = '0;
          res_valid_o      = 1'b1;
          res_o.kind       = clip ? EV_CLIP : EV_RUN;
          res_o.blue       = part[7:0];
          res_o.green      = part[15:8];
          res_o.red        = part[23:16];
          res_o.alpha      = data;
          res_o.col_start  = col;
          res_o.row_addr   = rows_m1;
          res_o.run_length = run_n;
          if (ph == PH_PIXELS) begin
            pleft_d = prep ? 8'd0 : pleft_m1;
          end
          if (wrap) begin
            col_d  = '0;
            rows_d = rows_m1;
          end else begin
            col_d = col_sum[15:0];
          end
          if (wrap && rows_m1 == '0) begin
            ph_d             = PH_DONE;
            res_o.image_done = 1'b1;
          end else if (ph == PH_PIXELS) begin
            if (prep) begin
              ph_d = PH_PACKET;
            end else if (clip) begin
              ph_d = PH_SKIP;
            end else if (pleft_m1 == '0) begin
              ph_d = PH_PACKET;
            end
          end
        end
      end
      PH_SKIP: begin
        if (bip != 2'd3) begin
          bip_d = bip + 2'd1;
        end else begin
          bip_d   = '0;
          pleft_d = pleft_m1;
          if (pleft_m1 == '0) begin
            ph_d = PH_PACKET;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidx_q  <= '0;
      ph_q    <= PH_HEADER;
      kind_q  <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      rows_q  <= '0;
      col_q   <= '0;
      pleft_q <= '0;
      prep_q  <= 1'b0;
      bip_q   <= '0;
      part_q  <= '0;
    end else if (step_i) begin
      hidx_q  <= hidx_d;
      ph_q    <= ph_d;
      kind_q  <= kind_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      rows_q  <= rows_d;
      col_q   <= col_d;
      pleft_q <= pleft_d;
      prep_q  <= prep_d;
      bip_q   <= bip_d;
      part_q  <= part_d;
    end
  end

endmodule

// ===== src/tga_dec_out_reg.sv =====
module tga_dec_out_reg import tga_dec_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== src/tga_rle_image_decoder.sv =====
// Streaming decoder for 32-bit TGA files, uncompressed (type 2) or run-length
// coded (type 10). Feed the file one byte per word with tuser high on its
// first byte. Words out: one header word after the 18-byte header (tuser 1,
// width and height), a depth-error word if the depth byte is not 32 (tuser 2,
// rest of the file ignored), then pixel runs (tuser 0, or 3 when a packet was
// cut at the row end). Rows count down from height-1; tlast marks the run
// that finishes row 0. Other image types, empty images and bytes past the
// image give nothing until the next file start. The image ID field is not
// skipped. One byte is taken every cycle; a result passes the input register
// and then the output register, and throughput drops only while the output
// is stalled with a result waiting in the output register.
module tga_rle_image_decoder import tga_dec_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // data_byte
  input  logic         s_axis_tuser_i,  // file_start
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // blue, green, red, alpha, col_start, row_addr, run_length, width,
  // height
  output logic [103:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o,  // event_kind
  output logic         m_axis_tlast_o   // image_done
);

  in_word_t in_word;
  in_word_t stage_word;
  logic     stage_valid;
  logic     fire;
  logic     res_valid;
  result_t  res;
  logic     out_valid;
  result_t  out_res;

  assign in_word.data  = s_axis_tdata_i;
  assign in_word.start = s_axis_tuser_i;

  assign fire = stage_valid && (!res_valid || !out_valid || m_axis_tready_i);

  tga_dec_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .word_i  (in_word),
    .take_i  (fire),
    .valid_o (stage_valid),
    .word_o  (stage_word)
  );

  tga_dec_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (stage_word),
    .step_i      (fire),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tga_dec_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready_i),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tuser_o  = out_res.kind;
  assign m_axis_tlast_o  = out_res.image_done;
  assign m_axis_tdata_o  = {out_res.frame_height, out_res.frame_width,
                            out_res.run_length, out_res.row_addr, out_res.col_start,
                            out_res.alpha, out_res.red, out_res.green, out_res.blue};

  // a byte waiting with room downstream is always taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && (!out_valid || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stage stalled with free output");

  // a new result only follows a processed byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(fire))
    else $error("result appeared without a processed byte");

  // pixel runs carry a run length of 1 to 128
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_res.kind == EV_RUN || out_res.kind == EV_CLIP)
    |-> out_res.run_length != 8'd0 && out_res.run_length <= 8'd128)
    else $error("run length out of range");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import tga_dec_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int ItemTarget    = 1050;

  class tga_scoreboard;
    phase_e      phase;
    logic [4:0]  hdr_idx;
    logic [7:0]  img_type;
    logic [15:0] wid;
    logic [15:0] hgt;
    logic [15:0] rows_left;
    logic [15:0] col;
    logic [7:0]  pkt_left;
    bit          pkt_rep;
    logic [1:0]  pix_byte;
    logic [23:0] bgr;
    result_t     runs_due[$];
    int          errors;
    int          words;
    int          parsed;
    int          ev_seen[4];

    function new();
      restart();
      errors = 0;
      words  = 0;
      parsed = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
    endfunction

    function void restart();
      phase     = PH_HEADER;
      hdr_idx   = '0;
      img_type  = '0;
      wid       = '0;
      hgt       = '0;
      rows_left = '0;
      col       = '0;
      pkt_left  = '0;
      pkt_rep   = 1'b0;
      pix_byte  = '0;
      bgr       = '0;
    endfunction

    function result_t run_word(event_e k, logic [7:0] a, logic [7:0] len);
      result_t r;
      r            = '0;
      r.kind       = k;
      r.blue       = bgr[7:0];
      r.green      = bgr[15:8];
      r.red        = bgr[23:16];
      r.alpha      = a;
      r.col_start  = col;
      r.row_addr   = rows_left - 16'd1;
      r.run_length = len;
      return r;
    endfunction

    // returns 1 when row 0 has just been finished
    function bit step_past(logic [15:0] n);
      logic [16:0] c;
      c = {1'b0, col} + {1'b0, n};
      if (c >= {1'b0, wid}) begin
        col       = '0;
        rows_left = rows_left - 16'd1;
        if (rows_left == 16'd0) begin
          phase = PH_DONE;
          return 1'b1;
        end
      end else begin
        col = c[15:0];
      end
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic st);
      result_t     r;
      bit          emit;
      bit          clip;
      logic [15:0] avail;
      logic [7:0]  n;
      logic [4:0]  idx;
      r    = '0;
      emit = 1'b0;
      if (st) restart();
      if (phase != PH_DONE) parsed++;
      case (phase)
        PH_HEADER: begin
          idx     = hdr_idx;
          hdr_idx = hdr_idx + 5'd1;
          case (idx)
            HdrImageType: img_type = b;
            HdrWidthLo:   wid[7:0] = b;
            HdrWidthHi:   wid[15:8] = b;
            HdrHeightLo:  hgt[7:0] = b;
            HdrHeightHi:  hgt[15:8] = b;
            HdrDepth: begin
              if (b != DepthBgra) begin
                phase  = PH_DONE;
                r.kind = EV_DEPTH;
                emit   = 1'b1;
              end
            end
            HdrLast: begin
              rows_left = hgt;
              col       = '0;
              if (wid == 16'd0 || hgt == 16'd0) phase = PH_DONE;
              else if (img_type == TypeTrueColor) phase = PH_PLAIN;
              else if (img_type == TypeRle) phase = PH_PACKET;
              else phase = PH_DONE;
              r.kind         = EV_HEADER;
              r.frame_width  = wid;
              r.frame_height = hgt;
              emit           = 1'b1;
            end
            default: ;
          endcase
        end
        PH_PACKET: begin
          pkt_rep  = b[7];
          pkt_left = b[7] ? b - RepeatBias : b + 8'd1;
          pix_byte = '0;
          bgr      = '0;
          phase    = PH_PIXELS;
        end
        PH_PLAIN, PH_PIXELS: begin
          if (pix_byte < 2'd3) begin
            bgr[8*pix_byte +: 8] = b;
            pix_byte++;
          end else begin
            pix_byte = '0;
            emit     = 1'b1;
            if (phase == PH_PLAIN) begin
              r            = run_word(EV_RUN, b, 8'd1);
              r.image_done = step_past(16'd1);
            end else if (pkt_rep) begin
              avail    = wid - col;
              clip     = {8'd0, pkt_left} > avail;
              n        = clip ? avail[7:0] : pkt_left;
              r        = run_word(clip ? EV_CLIP : EV_RUN, b, n);
              pkt_left = '0;
              if (step_past({8'd0, n})) r.image_done = 1'b1;
              else phase = PH_PACKET;
            end else begin
              clip     = (col + 17'd1 == {1'b0, wid}) && pkt_left > 8'd1;
              r        = run_word(clip ? EV_CLIP : EV_RUN, b, 8'd1);
              pkt_left = pkt_left - 8'd1;
              if (step_past(16'd1)) r.image_done = 1'b1;
              else if (clip) phase = PH_SKIP;
              else if (pkt_left == 8'd0) phase = PH_PACKET;
            end
            bgr = '0;
          end
        end
        PH_SKIP: begin
          if (pix_byte < 2'd3) begin
            pix_byte++;
          end else begin
            pix_byte = '0;
            pkt_left = pkt_left - 8'd1;
            if (pkt_left == 8'd0) phase = PH_PACKET;
          end
        end
        default: ;
      endcase
      if (emit) runs_due.insert(runs_due.size(), r);
    endfunction

    function void cmp_field(string name, logic [15:0] e, logic [15:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_word(logic [103:0] d, logic [1:0] u, logic l);
      result_t e;
      if (runs_due.size() == 0) begin
        errors++;
        $display("%0t: word with nothing expected, expected none actual tuser %0h tdata %h",
                 $time, u, d);
        return;
      end
      e = runs_due.pop_front();
      words++;
      ev_seen[e.kind]++;
      cmp_field("event kind", 16'(e.kind), 16'(u));
      cmp_field("blue", 16'(e.blue), 16'(d[7:0]));
      cmp_field("green", 16'(e.green), 16'(d[15:8]));
      cmp_field("red", 16'(e.red), 16'(d[23:16]));
      cmp_field("alpha", 16'(e.alpha), 16'(d[31:24]));
      cmp_field("col_start", e.col_start, d[47:32]);
      cmp_field("row_addr", e.row_addr, d[63:48]);
      cmp_field("run_length", 16'(e.run_length), 16'(d[71:64]));
      cmp_field("frame width", e.frame_width, d[87:72]);
      cmp_field("frame height", e.frame_height, d[103:88]);
      cmp_field("image_done", 16'(e.image_done), 16'(l));
    endfunction
  endclass

  logic         clk      = 1'b0;
  logic         rst_n    = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = '0;
  logic         s_tuser  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  tga_scoreboard sb = new();
  in_word_t      file_q[$];
  int            src_idle   = 32;
  int            dst_idle   = 55;
  int            ready_calm = 0;
  int            stuck      = 0;
  int            files      = 0;
  int            sent_bytes = 0;
  int            base;
  bit            src_calm;
  bit            took_in;
  bit            took_out;

  tga_rle_image_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (ready_calm > 0) begin
      m_tready   <= 1'b1;
      ready_calm <= ready_calm - 1;
    end else if ($urandom_range(99) < 4) begin
      m_tready   <= 1'b1;
      ready_calm <= $urandom_range(10, 40);
    end else begin
      m_tready <= $urandom_range(99) >= dst_idle;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      took_in  = s_tvalid && s_tready;
      took_out = m_tvalid && m_tready;
      if (took_in) sb.note_byte(s_tdata, s_tuser);
      if (took_out) sb.check_word(m_tdata, m_tuser, m_tlast);
      if (took_in || took_out) stuck = 0;
      else stuck++;
      if (stuck >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, stuck, sb.runs_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void add_byte(logic [7:0] b, logic st);
    file_q.insert(file_q.size(), in_word_t'{data: b, start: st});
  endfunction

  function automatic void add_pixel(logic [31:0] p);
    for (int i = 0; i < 4; i++) add_byte(p[8*i +: 8], 1'b0);
  endfunction

  function automatic void add_header(logic st, logic [7:0] ty, logic [15:0] w,
                                     logic [15:0] h, logic [7:0] depth);
    logic [7:0] b;
    for (int i = 0; i < 18; i++) begin
      case (i)
        HdrImageType: b = ty;
        HdrWidthLo:   b = w[7:0];
        HdrWidthHi:   b = w[15:8];
        HdrHeightLo:  b = h[7:0];
        HdrHeightHi:  b = h[15:8];
        HdrDepth:     b = depth;
        default:      b = 8'($urandom_range(255));
      endcase
      add_byte(b, st && i == 0);
    end
  endfunction

  // packets laid out so the image completes, with runs hitting and crossing row ends
  function automatic void add_rle_body(int w, int h);
    int col;
    int rows;
    int cnt;
    bit rep;
    col  = 0;
    rows = h;
    while (rows > 0) begin
      rep = 1'($urandom_range(1));
      case ($urandom_range(3))
        0:       cnt = $urandom_range(1, 3);
        1:       cnt = w - col;
        2:       cnt = w - col + $urandom_range(1, 3);
        default: cnt = rep ? $urandom_range(1, 128) : $urandom_range(1, 6);
      endcase
      if (cnt > 128) cnt = 128;
      if (rep) begin
        add_byte(8'(RepeatBias + cnt), 1'b0);
        add_pixel($urandom);
      end else begin
        add_byte(8'(cnt - 1), 1'b0);
        repeat (cnt) add_pixel($urandom);
      end
      col += (cnt < w - col) ? cnt : w - col;
      if (col >= w) begin
        col = 0;
        rows--;
      end
    end
  endfunction

  function automatic void build_random_file();
    int         pick;
    int         w;
    int         h;
    int         keep;
    logic [7:0] b;
    pick = $urandom_range(99);
    w    = $urandom_range(1, 8);
    h    = $urandom_range(1, 4);
    if (pick < 45) begin
      add_header(1'b1, TypeRle, 16'(w), 16'(h), DepthBgra);
      add_rle_body(w, h);
    end else if (pick < 75) begin
      add_header(1'b1, TypeTrueColor, 16'(w), 16'(h), DepthBgra);
      repeat (w * h) add_pixel($urandom);
    end else if (pick < 82) begin
      b = 8'($urandom_range(255));
      if (b == DepthBgra) b = 8'd24;
      add_header(1'b1, pick[0] ? TypeRle : TypeTrueColor, 16'(w), 16'(h), b);
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)), 1'b0);
    end else if (pick < 88) begin
      b = 8'($urandom_range(255));
      if (b == TypeTrueColor || b == TypeRle) b = 8'd1;
      add_header(1'b1, b, 16'(w), 16'(h), DepthBgra);
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)), 1'b0);
    end else if (pick < 94) begin
      add_header(1'b1, pick[0] ? TypeRle : TypeTrueColor, pick[1] ? 16'd0 : 16'(w),
                 pick[1] ? 16'(h) : 16'd0, DepthBgra);
      add_pixel($urandom);
    end else begin
      add_byte(8'($urandom_range(255)), 1'b1);
      repeat ($urandom_range(10, 40)) add_byte(8'($urandom_range(255)), 1'b0);
    end
    if ($urandom_range(99) < 8 && file_q.size() > 1) begin
      keep = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)), 1'b0);
    if ($urandom_range(99) < 5) file_q[0].start = 1'b0;
  endfunction

  task automatic send_word(in_word_t w);
    while (!src_calm && $urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w.data;
    s_tuser  <= w.start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_file();
    src_calm = $urandom_range(99) < 15;
    foreach (file_q[i]) send_word(file_q[i]);
    sent_bytes += file_q.size();
    file_q.delete();
    files++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.runs_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no file start after reset, extreme pixel values
    add_header(1'b0, TypeTrueColor, 16'd2, 16'd1, DepthBgra);
    add_pixel(32'hffff_ffff);
    add_pixel(32'h0000_0000);
    send_file();
    // wrong depth, the rest of the file is ignored
    add_header(1'b1, TypeRle, 16'd4, 16'd4, 8'd24);
    repeat (4) add_byte(8'($urandom_range(255)), 1'b0);
    send_file();
    // unknown image type
    add_header(1'b1, 8'd3, 16'd2, 16'd1, DepthBgra);
    add_pixel($urandom);
    send_file();
    // empty images
    add_header(1'b1, TypeTrueColor, 16'd0, 16'd5, DepthBgra);
    add_pixel($urandom);
    send_file();
    add_header(1'b1, TypeRle, 16'd7, 16'd0, DepthBgra);
    add_byte(8'h81, 1'b0);
    add_pixel($urandom);
    send_file();
    // raw packet across the row end, then a clipped repeat ends the image
    add_header(1'b1, TypeRle, 16'd3, 16'd2, DepthBgra);
    add_byte(8'h04, 1'b0);
    repeat (5) add_pixel($urandom);
    add_byte(8'hff, 1'b0);
    add_pixel($urandom);
    repeat (3) add_byte(8'($urandom_range(255)), 1'b0);
    send_file();
    // longest and shortest repeat, single raw, clipped longest repeat
    add_header(1'b1, TypeRle, 16'd200, 16'd1, DepthBgra);
    add_byte(8'hff, 1'b0);
    add_pixel($urandom);
    add_byte(8'h80, 1'b0);
    add_pixel($urandom);
    add_byte(8'h00, 1'b0);
    add_pixel($urandom);
    add_byte(8'hff, 1'b0);
    add_pixel($urandom);
    send_file();
    // largest sizes and longest raw packet, cut short by the next file
    add_header(1'b1, TypeRle, 16'hffff, 16'hffff, DepthBgra);
    add_byte(8'hff, 1'b0);
    add_pixel($urandom);
    add_byte(8'h7f, 1'b0);
    add_pixel($urandom);
    add_pixel($urandom);
    send_file();
    // restart in the middle of a pixel
    add_header(1'b1, TypeTrueColor, 16'd2, 16'd2, DepthBgra);
    add_pixel($urandom);
    add_byte(8'($urandom_range(255)), 1'b0);
    add_byte(8'($urandom_range(255)), 1'b0);
    send_file();
    wait_drained();

    base = sent_bytes;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 32 : (ph == 1) ? 55 : 0;
      dst_idle = (ph == 0) ? 55 : (ph == 1) ? 32 : 0;
      while (sent_bytes - base < (ItemTarget - base) * (ph + 1) / 3) begin
        build_random_file();
        send_file();
      end
      wait_drained();
    end
    repeat (10) @(posedge clk);

    $display("sent %0d files, %0d bytes, %0d parsed, %0d result words checked",
             files, sent_bytes, sb.parsed, sb.words);
    $display("pixel runs %0d, headers %0d, depth errors %0d, clipped runs %0d",
             sb.ev_seen[EV_RUN], sb.ev_seen[EV_HEADER], sb.ev_seen[EV_DEPTH],
             sb.ev_seen[EV_CLIP]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
